// ===== rtl/assert_macros.svh =====
// Assertion macros used by the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ARA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ARA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARA_ASSERT(label, clk, rst, prop, msg)
`define ARA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/ara_pkg.sv =====
// Package: types, codes and defaults of the address region allocator.
package ara_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 32;
  localparam int unsigned DEF_PAGE_BYTES    = 4096;
  localparam logic [31:0] LOW_END_MIN       = 32'h0000_4000;

  localparam logic [31:0] RST_BASE_START = 32'd3221225472;
  localparam logic [31:0] RST_FREE_START = 32'd3225419776;
  localparam logic [31:0] RST_FREE_END   = 32'd4290772992;
  localparam logic [5:0]  RST_RESERVE    = 6'd2;

  typedef enum logic [2:0] {
    REG_BASE_START = 3'd0,
    REG_FREE_START = 3'd1,
    REG_FREE_END   = 3'd2,
    REG_RESERVE    = 3'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FIND  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOFIT   = 2'd1,
    STAT_NOSPARE = 2'd2,
    STAT_NOTUSED = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_FREE   = 2'd1,
    ST_USED   = 2'd2
  } ent_state_t;

  typedef enum logic [3:0] {
    S_INIT0, S_INIT1, S_IDLE, S_ROUND, S_ARD, S_AEVAL, S_ADECIDE,
    S_WRBEST, S_FRD, S_FEVAL, S_MRD, S_MEVAL, S_MDONE, S_DONE
  } seq_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] size;
  } round_res_t;

endpackage

// ===== rtl/address_region_allocator_core.sv =====
// Top level: region table, scan sequencer and result registers.
// Find: each entry is read, then evaluated; the scan stops at the first used region holding the address.
// Free adds a merge scan that restarts after each merge, a final scan and a write of the merged entry.
// Allocate: page rounding, one full scan, a decision and a write, merge scans on split.
// One request at a time; busy stays high until the done strobe. The receiver cannot stall.
// Reset or a write to one of the four config registers rebuilds the table in S_INIT0 and S_INIT1, busy high meanwhile.
`include "assert_macros.svh"
module address_region_allocator_core #(
  parameter int unsigned TABLE_ENTRIES = ara_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned PAGE_BYTES    = ara_pkg::DEF_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] req_size,
  input  logic [31:0] req_addr,
  input  logic [7:0]  region_kind,
  input  logic [7:0]  handler_id,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] region_addr,
  output logic [31:0] region_size,
  output logic [7:0]  found_kind,
  output logic [7:0]  found_handler,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned SW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CW = (SW > 6) ? SW : 6;

  ara_pkg::seq_t state, state_next;
  ara_pkg::ent_state_t ent_state [TABLE_ENTRIES];
  ara_pkg::round_res_t rnd;

  logic [31:0] mem_start  [TABLE_ENTRIES];
  logic [31:0] mem_len    [TABLE_ENTRIES];
  logic [7:0]  mem_flags  [TABLE_ENTRIES];
  logic [7:0]  mem_hdl    [TABLE_ENTRIES];
  logic [31:0] mem_age    [TABLE_ENTRIES];

  logic [31:0] rd_start, rd_len, rd_age;
  logic [7:0]  rd_flags, rd_hdl;

  logic [31:0] base_r, fstart_r, fend_r;
  logic [5:0]  reserve_r;
  logic [31:0] age_ctr;
  logic [SW-1:0] spare;

  logic [1:0]  op_r;
  logic [31:0] addr_r;
  logic [7:0]  kind_r, hid_r;
  logic [31:0] size_r;
  logic [IW-1:0] cnt;
  logic        best_v, x_v, split;
  logic [IW-1:0] best_idx, x_idx, d_idx;
  logic [31:0] best_len, best_age, best_start;
  logic [31:0] dstart, dlen;

  logic [1:0]  res_status;
  logic [31:0] res_addr, res_size;
  logic [7:0]  res_kind, res_hdl;

  logic        we_start, we_len, we_fh, we_age;
  logic [IW-1:0] waddr;
  logic [31:0] wd_start, wd_len, wd_age;
  logic [7:0]  wd_flags, wd_hdl;

  logic        cfg_hit, accept, last;
  ara_pkg::ent_state_t st_k;
  logic        better, contain, merge_up, merge_down, spare_ok, low_end;
  logic [31:0] x_len;

  assign cfg_hit = cfg_we && (cfg_idx == ara_pkg::REG_BASE_START ||
                   cfg_idx == ara_pkg::REG_FREE_START || cfg_idx == ara_pkg::REG_FREE_END ||
                   cfg_idx == ara_pkg::REG_RESERVE);
  assign busy    = (state != ara_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign last    = (cnt == IW'(TABLE_ENTRIES - 1));
  assign st_k    = ent_state[cnt];
  assign better  = (st_k == ara_pkg::ST_FREE) && (rd_len >= size_r) &&
                   (!best_v || rd_len < best_len || (rd_len == best_len && rd_age > best_age));
  assign contain = (st_k == ara_pkg::ST_USED) && (addr_r >= rd_start) &&
                   ({1'b0, addr_r} < ({1'b0, rd_start} + {1'b0, rd_len}));
  assign merge_up   = (cnt != d_idx) && (st_k == ara_pkg::ST_FREE) && (dstart + dlen == rd_start);
  assign merge_down = (cnt != d_idx) && (st_k == ara_pkg::ST_FREE) && (rd_start + rd_len == dstart);
  assign spare_ok = (CW'(spare) > CW'(reserve_r)) && (spare != '0) && x_v;
  assign low_end  = (size_r >= ara_pkg::LOW_END_MIN);
  assign x_len    = best_len - size_r;

  ara_round #(.PAGE_BYTES(PAGE_BYTES)) u_round (
    .clk (clk),
    .rst (rst),
    .go  (accept && ara_pkg::op_t'(op) == ara_pkg::OP_ALLOC),
    .req (req_size),
    .res (rnd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ara_pkg::S_INIT0:   state_next = ara_pkg::S_INIT1;
      ara_pkg::S_INIT1:   state_next = ara_pkg::S_IDLE;
      ara_pkg::S_IDLE: begin
        if (start) begin
          unique case (ara_pkg::op_t'(op))
            ara_pkg::OP_ALLOC: state_next = ara_pkg::S_ROUND;
            ara_pkg::OP_FREE,
            ara_pkg::OP_FIND:  state_next = ara_pkg::S_FRD;
            default:           state_next = ara_pkg::S_DONE;
          endcase
        end
      end
      ara_pkg::S_ROUND: begin
        if (rnd.done) state_next = rnd.ovf ? ara_pkg::S_DONE : ara_pkg::S_ARD;
      end
      ara_pkg::S_ARD:     state_next = ara_pkg::S_AEVAL;
      ara_pkg::S_AEVAL:   state_next = last ? ara_pkg::S_ADECIDE : ara_pkg::S_ARD;
      ara_pkg::S_ADECIDE: begin
        if (!best_v) state_next = ara_pkg::S_DONE;
        else if (best_len == size_r || spare_ok) state_next = ara_pkg::S_WRBEST;
        else state_next = ara_pkg::S_DONE;
      end
      ara_pkg::S_WRBEST:  state_next = split ? ara_pkg::S_MRD : ara_pkg::S_DONE;
      ara_pkg::S_FRD:     state_next = ara_pkg::S_FEVAL;
      ara_pkg::S_FEVAL: begin
        if (contain) begin
          state_next = (ara_pkg::op_t'(op_r) == ara_pkg::OP_FREE) ? ara_pkg::S_MRD
                                                                   : ara_pkg::S_DONE;
        end else begin
          state_next = last ? ara_pkg::S_DONE : ara_pkg::S_FRD;
        end
      end
      ara_pkg::S_MRD:     state_next = ara_pkg::S_MEVAL;
      ara_pkg::S_MEVAL: begin
        if (merge_up || merge_down || !last) state_next = ara_pkg::S_MRD;
        else state_next = ara_pkg::S_MDONE;
      end
      ara_pkg::S_MDONE:   state_next = ara_pkg::S_DONE;
      ara_pkg::S_DONE:    state_next = ara_pkg::S_IDLE;
      default:            state_next = ara_pkg::S_INIT0;
    endcase
    if (cfg_hit) state_next = ara_pkg::S_INIT0;
  end

  always_comb begin
    we_start = 1'b0;
    we_len   = 1'b0;
    we_fh    = 1'b0;
    we_age   = 1'b0;
    waddr    = '0;
    wd_start = '0;
    wd_len   = '0;
    wd_flags = '0;
    wd_hdl   = '0;
    wd_age   = '0;
    unique case (state)
      ara_pkg::S_INIT0: begin
        {we_start, we_len, we_fh, we_age} = 4'b1111;
        wd_start = base_r;
        wd_len   = fstart_r - base_r;
      end
      ara_pkg::S_INIT1: begin
        {we_start, we_len, we_fh, we_age} = 4'b1111;
        waddr    = IW'(1);
        wd_start = fstart_r;
        wd_len   = fend_r - fstart_r;
      end
      ara_pkg::S_WRBEST: begin
        {we_start, we_len, we_fh} = 3'b111;
        waddr    = best_idx;
        wd_start = best_start;
        wd_len   = size_r;
        wd_flags = kind_r;
        wd_hdl   = hid_r;
      end
      ara_pkg::S_MDONE: begin
        {we_start, we_len, we_age} = 3'b111;
        waddr    = d_idx;
        wd_start = dstart;
        wd_len   = dlen;
        wd_age   = age_ctr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_start) mem_start[waddr] <= wd_start;
    if (we_len)   mem_len[waddr]   <= wd_len;
    if (we_fh) begin
      mem_flags[waddr] <= wd_flags;
      mem_hdl[waddr]   <= wd_hdl;
    end
    if (we_age)   mem_age[waddr]   <= wd_age;
    rd_start <= mem_start[cnt];
    rd_len   <= mem_len[cnt];
    rd_flags <= mem_flags[cnt];
    rd_hdl   <= mem_hdl[cnt];
    rd_age   <= mem_age[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ara_pkg::S_INIT0;
      base_r    <= ara_pkg::RST_BASE_START;
      fstart_r  <= ara_pkg::RST_FREE_START;
      fend_r    <= ara_pkg::RST_FREE_END;
      reserve_r <= ara_pkg::RST_RESERVE;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_idx)
          ara_pkg::REG_BASE_START: base_r    <= cfg_data;
          ara_pkg::REG_FREE_START: fstart_r  <= cfg_data;
          ara_pkg::REG_FREE_END:   fend_r    <= cfg_data;
          ara_pkg::REG_RESERVE:    reserve_r <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) ent_state[i] <= ara_pkg::ST_UNUSED;
      ent_state[0] <= ara_pkg::ST_USED;
      ent_state[1] <= ara_pkg::ST_FREE;
      age_ctr <= 32'd1;
      spare   <= SW'(TABLE_ENTRIES - 2);
      cnt     <= '0;
    end else begin
      unique case (state)
        ara_pkg::S_IDLE: begin
          if (start) begin
            op_r       <= op;
            addr_r     <= req_addr;
            kind_r     <= region_kind;
            hid_r      <= handler_id;
            cnt        <= '0;
            best_v     <= 1'b0;
            x_v        <= 1'b0;
            split      <= 1'b0;
            res_status <= (ara_pkg::op_t'(op) == ara_pkg::OP_NONE) ? ara_pkg::STAT_NOTUSED
                                                                   : ara_pkg::STAT_OK;
            res_addr   <= '0;
            res_size   <= '0;
            res_kind   <= '0;
            res_hdl    <= '0;
          end
        end
        ara_pkg::S_ROUND: begin
          if (rnd.done) begin
            size_r <= rnd.size;
            if (rnd.ovf) res_status <= ara_pkg::STAT_NOFIT;
          end
        end
        ara_pkg::S_AEVAL: begin
          if (better) begin
            best_v     <= 1'b1;
            best_idx   <= cnt;
            best_len   <= rd_len;
            best_age   <= rd_age;
            best_start <= rd_start;
          end
          if (st_k == ara_pkg::ST_UNUSED && !x_v) begin
            x_v   <= 1'b1;
            x_idx <= cnt;
          end
          if (!last) cnt <= cnt + IW'(1);
        end
        ara_pkg::S_ADECIDE: begin
          cnt <= '0;
          if (!best_v) begin
            res_status <= ara_pkg::STAT_NOFIT;
          end else if (best_len == size_r) begin
            ent_state[best_idx] <= ara_pkg::ST_USED;
          end else if (!spare_ok) begin
            res_status <= ara_pkg::STAT_NOSPARE;
          end else begin
            split               <= 1'b1;
            spare               <= spare - SW'(1);
            ent_state[best_idx] <= ara_pkg::ST_USED;
            ent_state[x_idx]    <= ara_pkg::ST_FREE;
            d_idx               <= x_idx;
            dlen                <= x_len;
            if (low_end) begin
              dstart <= best_start + size_r;
            end else begin
              dstart     <= best_start;
              best_start <= best_start + x_len;
            end
          end
        end
        ara_pkg::S_WRBEST: begin
          res_addr <= best_start;
          res_size <= size_r;
          res_kind <= kind_r;
          res_hdl  <= hid_r;
        end
        ara_pkg::S_FEVAL: begin
          if (contain) begin
            res_addr <= rd_start;
            res_size <= rd_len;
            res_kind <= rd_flags;
            res_hdl  <= rd_hdl;
            d_idx    <= cnt;
            dstart   <= rd_start;
            dlen     <= rd_len;
            cnt      <= '0;
            if (ara_pkg::op_t'(op_r) == ara_pkg::OP_FREE) ent_state[cnt] <= ara_pkg::ST_FREE;
          end else if (last) begin
            res_status <= ara_pkg::STAT_NOTUSED;
          end else begin
            cnt <= cnt + IW'(1);
          end
        end
        ara_pkg::S_MEVAL: begin
          if (merge_up) begin
            dlen           <= dlen + rd_len;
            ent_state[cnt] <= ara_pkg::ST_UNUSED;
            spare          <= spare + SW'(1);
            cnt            <= '0;
          end else if (merge_down) begin
            dstart           <= rd_start;
            dlen             <= rd_len + dlen;
            ent_state[d_idx] <= ara_pkg::ST_UNUSED;
            d_idx            <= cnt;
            spare            <= spare + SW'(1);
            cnt              <= '0;
          end else if (!last) begin
            cnt <= cnt + IW'(1);
          end
        end
        ara_pkg::S_MDONE: begin
          age_ctr <= age_ctr + 32'd1;
        end
        default: ;
      endcase
    end
  end

  assign done          = (state == ara_pkg::S_DONE);
  assign status        = res_status;
  assign region_addr   = res_addr;
  assign region_size   = res_size;
  assign found_kind    = res_kind;
  assign found_handler = res_hdl;

  `ARA_ASSERT(a_done_busy, clk, rst, done |-> busy, "done strobe outside a request")
  `ARA_ASSERT(a_accept_busy, clk, rst, (accept && !cfg_hit) |=> busy, "request accepted but not busy")
  `ARA_ASSERT(a_spare_range, clk, rst, spare <= SW'(TABLE_ENTRIES - 1), "spare count out of range")
  `ARA_ASSERT(a_fail_zero, clk, rst,
    (done && res_status != ara_pkg::STAT_OK) |-> (res_addr == '0 && res_size == '0),
    "failed request reports a region")

endmodule

// ===== rtl/ara_round.sv =====
// Page round-up unit: reciprocal multiply for the page remainder, then add the page complement.
module ara_round #(
  parameter int unsigned PAGE_BYTES = ara_pkg::DEF_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [31:0]          req,
  output ara_pkg::round_res_t  res
);

  localparam int unsigned     LG    = $clog2(PAGE_BYTES);
  localparam int unsigned     SH1   = (LG > 0) ? 1 : 0;
  localparam int unsigned     SH2   = (LG > 0) ? LG - 1 : 0;
  localparam longint unsigned MFULL = ((64'd1 << (32 + LG)) / 64'(PAGE_BYTES)) + 64'd1;
  localparam logic [31:0]     MLO   = 32'(MFULL - (64'd1 << 32));
  localparam logic [31:0]     PV    = 32'(PAGE_BYTES);

  logic [1:0]  ph;
  logic        done_r;
  logic [31:0] req_r;
  logic [31:0] t1;
  logic [31:0] quo;
  logic [31:0] quo_next;
  logic [31:0] qd;
  logic [31:0] rem;
  logic [63:0] prod;
  logic [31:0] adj;
  logic [32:0] sum;

  assign prod     = {32'd0, req_r} * {32'd0, MLO};
  assign quo_next = (t1 + ((req_r - t1) >> SH1)) >> SH2;
  assign qd       = quo * PV;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph     <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        req_r <= req;
        ph    <= 2'd1;
      end else begin
        unique case (ph)
          2'd1: begin
            t1 <= prod[63:32];
            ph <= 2'd2;
          end
          2'd2: begin
            quo <= quo_next;
            ph  <= 2'd3;
          end
          2'd3: begin
            rem    <= req_r - qd;
            done_r <= 1'b1;
            ph     <= 2'd0;
          end
          default: ;
        endcase
      end
    end
  end

  assign adj      = (rem == '0) ? '0 : PV - rem;
  assign sum      = {1'b0, req_r} + {1'b0, adj};
  assign res.done = done_r;
  assign res.ovf  = sum[32];
  assign res.size = sum[31:0];

endmodule
